[rtl/image_fit_dest_rect_macros.svh]
// Assertion macros for the image fit destination rectangle block.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef IMAGE_FIT_DEST_RECT_MACROS_SVH
`define IMAGE_FIT_DEST_RECT_MACROS_SVH

// Checked only outside reset.
`define IFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, also during reset.
`define IFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/ifd_pkg.sv]
// Shared codes for the image fit destination rectangle block.
// No dependencies.
`timescale 1ns / 1ps
package ifd_pkg;

  // Fit mode register codes; the remaining codes pass the content through.
  localparam logic [2:0] MODE_NATURAL    = 3'd0;
  localparam logic [2:0] MODE_CONTAIN    = 3'd1;
  localparam logic [2:0] MODE_COVER      = 3'd2;
  localparam logic [2:0] MODE_SCALE_DOWN = 3'd3;
  localparam logic [2:0] MODE_CUSTOM     = 3'd4;

  // Alignment codes per axis; the unused code behaves as start.
  localparam logic [1:0] ALIGN_START  = 2'd0;
  localparam logic [1:0] ALIGN_CENTER = 2'd1;
  localparam logic [1:0] ALIGN_END    = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_FIT_MODE      = 3'd0;
  localparam logic [2:0] REG_ALIGNMENT     = 3'd1;
  localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd2;
  localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd3;
  localparam logic [2:0] REG_CUSTOM_X      = 3'd4;
  localparam logic [2:0] REG_CUSTOM_Y      = 3'd5;
  localparam logic [2:0] REG_CUSTOM_WIDTH  = 3'd6;
  localparam logic [2:0] REG_CUSTOM_HEIGHT = 3'd7;

  // How a transaction is resolved once it has entered the pipeline.
  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_CUSTOM,
    KIND_NATURAL,
    KIND_SCALE
  } kind_e;

endpackage

[rtl/image_fit_dest_rect.sv]
// Image fit destination rectangle: places a source image inside a content rectangle.
// Depends on ifd_pkg and image_fit_dest_rect_macros.svh.
`timescale 1ns / 1ps
// Usage:
// Software first writes the fit mode, alignment, resolved source size and the
// custom rectangle through the configuration port (write enable, index, data),
// only while no transaction is in flight. Each input transaction carries a
// content rectangle; each output transaction carries the destination rectangle,
// every field saturated to the signed coordinate range.
// Both channels use valid and stall. A new transaction can be taken in every
// cycle unless a finished result is held up, so throughput is one rectangle per clock.
// Stage A forms the two aspect products, stage B picks the driving axis and
// forms the rounded numerator, the restoring divider resolves one quotient bit
// per stage (2*COORD_BITS - 1 stages), and the output stage does alignment
// and saturation.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_stall_o is raised in the same cycle, so nothing is lost or repeated; a
// bubble at the output lets everything advance.
// Reset clears all stage valid bits and returns the registers to natural
// mode, centered alignment, no image and a zero custom rectangle.
module image_fit_dest_rect
  import ifd_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_index_i,
  input  logic [COORD_BITS-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] content_x_i,
  input  logic signed [COORD_BITS-1:0] content_y_i,
  input  logic [COORD_BITS-2:0]        content_w_i,
  input  logic [COORD_BITS-2:0]        content_h_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] dest_x_o,
  output logic signed [COORD_BITS-1:0] dest_y_o,
  output logic signed [COORD_BITS-1:0] dest_w_o,
  output logic signed [COORD_BITS-1:0] dest_h_o
);

`include "image_fit_dest_rect_macros.svh"

  localparam int W  = COORD_BITS;
  localparam int U  = COORD_BITS - 1;
  localparam int P  = 2 * U;
  // Numerator width: product plus the rounding half; also the quotient width.
  localparam int NB = P + 1;
  // Wide signed width for positions computed from an unsaturated size.
  localparam int XW = NB + 3;
  localparam logic signed [XW-1:0] SAT_HI = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;

  // Per-transaction data carried alongside the arithmetic.
  typedef struct packed {
    logic signed [W-1:0] cx;
    logic signed [W-1:0] cy;
    logic [U-1:0]        cw;
    logic [U-1:0]        ch;
    kind_e               kind;
    logic                by_height;
  } meta_t;

  // Configuration registers.
  logic [2:0]          fit_mode_q;
  logic [3:0]          alignment_q;
  logic [U-1:0]        source_w_q;
  logic [U-1:0]        source_h_q;
  logic signed [W-1:0] custom_x_q;
  logic signed [W-1:0] custom_y_q;
  logic signed [W-1:0] custom_w_q;
  logic signed [W-1:0] custom_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q  <= MODE_NATURAL;
      alignment_q <= {ALIGN_CENTER, ALIGN_CENTER};
      source_w_q  <= '0;
      source_h_q  <= '0;
      custom_x_q  <= '0;
      custom_y_q  <= '0;
      custom_w_q  <= '0;
      custom_h_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FIT_MODE:      fit_mode_q  <= cfg_data_i[2:0];
        REG_ALIGNMENT:     alignment_q <= cfg_data_i[3:0];
        REG_SOURCE_WIDTH:  source_w_q  <= cfg_data_i[U-1:0];
        REG_SOURCE_HEIGHT: source_h_q  <= cfg_data_i[U-1:0];
        REG_CUSTOM_X:      custom_x_q  <= cfg_data_i;
        REG_CUSTOM_Y:      custom_y_q  <= cfg_data_i;
        REG_CUSTOM_WIDTH:  custom_w_q  <= cfg_data_i;
        REG_CUSTOM_HEIGHT: custom_h_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless a finished result is held up.
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Stage A: classify the transaction and form both aspect products.
  logic  a_valid_q;
  meta_t a_meta_q, a_meta_d;
  logic  a_cover_q, a_cover_d;
  logic [P-1:0] a_lhs_q, a_rhs_q;

  always_comb begin
    a_meta_d           = '0;
    a_meta_d.cx        = content_x_i;
    a_meta_d.cy        = content_y_i;
    a_meta_d.cw        = content_w_i;
    a_meta_d.ch        = content_h_i;
    a_meta_d.kind      = KIND_PASS;
    a_meta_d.by_height = 1'b0;
    a_cover_d          = 1'b0;
    if (source_w_q != '0 && source_h_q != '0) begin
      case (fit_mode_q)
        MODE_NATURAL: a_meta_d.kind = KIND_NATURAL;
        MODE_CONTAIN: a_meta_d.kind = KIND_SCALE;
        MODE_COVER: begin
          a_meta_d.kind = KIND_SCALE;
          a_cover_d     = 1'b1;
        end
        MODE_SCALE_DOWN: begin
          if (source_w_q <= content_w_i && source_h_q <= content_h_i) begin
            a_meta_d.kind = KIND_NATURAL;
          end else begin
            a_meta_d.kind = KIND_SCALE;
          end
        end
        MODE_CUSTOM: a_meta_d.kind = KIND_CUSTOM;
        default:     a_meta_d.kind = KIND_PASS;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_meta_q  <= a_meta_d;
      a_cover_q <= a_cover_d;
      a_lhs_q   <= P'(source_h_q) * P'(content_w_i);
      a_rhs_q   <= P'(content_h_i) * P'(source_w_q);
    end
  end

  // Stage B: choose the driving axis and add half the divisor for rounding.
  logic         b_valid_q;
  meta_t        b_meta_q, b_meta_d;
  logic [NB-1:0] b_num_q, b_num_d;
  logic [U-1:0] b_den_q, b_den_d;

  always_comb begin
    b_meta_d           = a_meta_q;
    b_meta_d.by_height = a_cover_q ? (a_lhs_q < a_rhs_q) : (a_lhs_q > a_rhs_q);
    if (b_meta_d.by_height) begin
      b_den_d = source_h_q;
      b_num_d = {1'b0, a_rhs_q} + {{(NB-U+1){1'b0}}, source_h_q[U-1:1]};
    end else begin
      b_den_d = source_w_q;
      b_num_d = {1'b0, a_lhs_q} + {{(NB-U+1){1'b0}}, source_w_q[U-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_meta_q <= b_meta_d;
      b_num_q  <= b_num_d;
      b_den_q  <= b_den_d;
    end
  end

  // Restoring divider: one quotient bit per stage. The numerator shifts out
  // of the top of nq while quotient bits shift in at the bottom.
  logic [NB-1:0] d_valid_q;
  meta_t         d_meta_q [NB];
  logic [U-1:0]  d_rem_q  [NB];
  logic [NB-1:0] d_nq_q   [NB];
  logic [U-1:0]  d_den_q  [NB];

  for (genvar i = 0; i < NB; i++) begin : g_div
    logic          src_valid;
    meta_t         src_meta;
    logic [U-1:0]  src_rem;
    logic [NB-1:0] src_nq;
    logic [U-1:0]  src_den;
    logic [U:0]    trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign src_valid = b_valid_q;
      assign src_meta  = b_meta_q;
      assign src_rem   = '0;
      assign src_nq    = b_num_q;
      assign src_den   = b_den_q;
    end else begin : g_next
      assign src_valid = d_valid_q[i-1];
      assign src_meta  = d_meta_q[i-1];
      assign src_rem   = d_rem_q[i-1];
      assign src_nq    = d_nq_q[i-1];
      assign src_den   = d_den_q[i-1];
    end

    assign trial = {src_rem, src_nq[NB-1]};
    assign ge    = trial >= {1'b0, src_den};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_valid_q[i] <= 1'b0;
      end else if (en) begin
        d_valid_q[i] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        d_meta_q[i] <= src_meta;
        d_den_q[i]  <= src_den;
        d_rem_q[i]  <= ge ? U'(trial - {1'b0, src_den}) : trial[U-1:0];
        d_nq_q[i]   <= {src_nq[NB-2:0], ge};
      end
    end
  end

  // Output stage: size per kind, alignment at full precision, saturation.
  function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] v);
    if (v > SAT_HI) begin
      sat = SAT_HI[W-1:0];
    end else if (v < SAT_LO) begin
      sat = SAT_LO[W-1:0];
    end else begin
      sat = v[W-1:0];
    end
  endfunction

  function automatic logic signed [XW-1:0] align(input logic signed [XW-1:0] org,
                                                 input logic signed [XW-1:0] csz,
                                                 input logic signed [XW-1:0] sz,
                                                 input logic [1:0] code);
    logic signed [XW-1:0] diff;
    diff = csz - sz;
    case (code)
      ALIGN_CENTER: align = org + (diff >>> 1);
      ALIGN_END:    align = org + diff;
      default:      align = org;
    endcase
  endfunction

  meta_t                fm;
  logic [NB-1:0]        quot;
  logic signed [XW-1:0] ox, oy, ow, oh, ocw, och, qx;

  assign fm   = d_meta_q[NB-1];
  assign quot = d_nq_q[NB-1];

  always_comb begin
    ocw = $signed({{(XW-U){1'b0}}, fm.cw});
    och = $signed({{(XW-U){1'b0}}, fm.ch});
    qx  = $signed({{(XW-NB){1'b0}}, quot});
    ox  = $signed({{(XW-W){fm.cx[W-1]}}, fm.cx});
    oy  = $signed({{(XW-W){fm.cy[W-1]}}, fm.cy});
    ow  = ocw;
    oh  = och;
    case (fm.kind)
      KIND_CUSTOM: begin
        ox = ox + $signed({{(XW-W){custom_x_q[W-1]}}, custom_x_q});
        oy = oy + $signed({{(XW-W){custom_y_q[W-1]}}, custom_y_q});
        ow = $signed({{(XW-W){custom_w_q[W-1]}}, custom_w_q});
        oh = $signed({{(XW-W){custom_h_q[W-1]}}, custom_h_q});
      end
      KIND_NATURAL: begin
        ow = $signed({{(XW-U){1'b0}}, source_w_q});
        oh = $signed({{(XW-U){1'b0}}, source_h_q});
        ox = align(ox, ocw, ow, alignment_q[1:0]);
        oy = align(oy, och, oh, alignment_q[3:2]);
      end
      KIND_SCALE: begin
        if (fm.by_height) begin
          ow = qx;
        end else begin
          oh = qx;
        end
        ox = align(ox, ocw, ow, alignment_q[1:0]);
        oy = align(oy, och, oh, alignment_q[3:2]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_valid_q[NB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dest_x_o <= sat(ox);
      dest_y_o <= sat(oy);
      dest_w_o <= sat(ow);
      dest_h_o <= sat(oh);
    end
  end

  assign out_valid_o = out_valid_q;

  // A held result freezes the numerator and divider stage valid bits.
  `IFD_ASSERT(a_stall_freezes, !en |=> $stable(d_valid_q) && $stable(b_valid_q), "pipeline moved while stalled")
  // A transaction leaving the last divider stage reaches the output.
  `IFD_ASSERT(a_div_to_out, en && d_valid_q[NB-1] |=> out_valid_o, "divider result dropped")
  // The rounded numerator enters the divider when the pipeline advances.
  `IFD_ASSERT(a_b_to_div, en && b_valid_q |=> d_valid_q[0], "numerator stage dropped")
  // For a scaled transaction the final remainder is below the divisor.
  `IFD_ASSERT(a_rem_bound, d_valid_q[NB-1] && fm.kind == KIND_SCALE |-> d_rem_q[NB-1] < d_den_q[NB-1], "divider remainder out of range")

endmodule

[tb/image_fit_dest_rect_tb.sv]
// Self-checking testbench for image_fit_dest_rect: drives content rectangles,
// predicts each destination rectangle and compares it with the block's output.
// Depends on ifd_pkg and the image_fit_dest_rect RTL.
`timescale 1ns / 1ps
module image_fit_dest_rect_tb;
  import ifd_pkg::*;

  localparam int CB = 24;
  localparam longint COORD_MAX = 64'sd8388607;
  localparam longint COORD_MIN = -64'sd8388608;
  // The pipeline is 2*CB+2 deep; leave some margin after the last result.
  localparam int DRAIN_CYCLES = 2 * CB + 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [CB-1:0] cx;
    logic signed [CB-1:0] cy;
    logic [CB-2:0] cw;
    logic [CB-2:0] ch;
  } content_rect_t;

  typedef struct {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] w;
    logic signed [CB-1:0] h;
  } dest_rect_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [CB-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [CB-1:0] content_x;
  logic signed [CB-1:0] content_y;
  logic [CB-2:0] content_w;
  logic [CB-2:0] content_h;
  logic out_valid;
  logic out_stall;
  logic signed [CB-1:0] dest_x;
  logic signed [CB-1:0] dest_y;
  logic signed [CB-1:0] dest_w;
  logic signed [CB-1:0] dest_h;

  // Shadow copy of the configuration registers, updated on every write.
  logic [2:0] mode_q;
  logic [3:0] align_q;
  longint src_w_q, src_h_q, cust_x_q, cust_y_q, cust_w_q, cust_h_q;

  content_rect_t pending_rects[$];
  dest_rect_t expected_rects[$];

  int error_count = 0;
  int rects_sent = 0;
  int rects_checked = 0;
  int config_phases = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_run = 0;
  int stall_style = 0;
  int style_left = 0;

  image_fit_dest_rect #(.COORD_BITS(CB)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .content_x_i (content_x),
    .content_y_i (content_y),
    .content_w_i (content_w),
    .content_h_i (content_h),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .dest_x_o    (dest_x),
    .dest_y_o    (dest_y),
    .dest_w_o    (dest_w),
    .dest_h_o    (dest_h)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [CB-1:0] saturate(longint v);
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v[CB-1:0];
  endfunction

  // Offset for a given alignment code; centering floors the half difference.
  function automatic longint place_axis(longint origin, longint csize, longint isize,
                                        logic [1:0] code);
    longint d;
    d = csize - isize;
    if (code == ALIGN_CENTER) return origin + ((d >= 0) ? d / 2 : -((-d + 1) / 2));
    if (code == ALIGN_END) return origin + d;
    return origin;
  endfunction

  // Computes the destination rectangle from the shadow registers.
  function automatic dest_rect_t fit_rect(content_rect_t c);
    dest_rect_t r;
    longint cx, cy, cw, ch, x, y, w, h, lhs, rhs;
    logic [2:0] m;
    bit by_height;
    cx = longint'(c.cx);
    cy = longint'(c.cy);
    cw = longint'({1'b0, c.cw});
    ch = longint'({1'b0, c.ch});
    x = cx; y = cy; w = cw; h = ch;
    m = mode_q;
    if (src_w_q != 0 && src_h_q != 0 && m <= MODE_CUSTOM) begin
      if (m == MODE_CUSTOM) begin
        x = cx + cust_x_q;
        y = cy + cust_y_q;
        w = cust_w_q;
        h = cust_h_q;
      end else begin
        if (m == MODE_SCALE_DOWN)
          m = (src_w_q <= cw && src_h_q <= ch) ? MODE_NATURAL : MODE_CONTAIN;
        if (m == MODE_NATURAL) begin
          w = src_w_q;
          h = src_h_q;
        end else begin
          lhs = src_h_q * cw;
          rhs = ch * src_w_q;
          by_height = (m == MODE_CONTAIN) ? (lhs > rhs) : (lhs < rhs);
          // The driving axis takes the content size; the other is rounded half up.
          if (by_height) begin
            h = ch;
            w = (src_w_q * ch + src_h_q / 2) / src_h_q;
          end else begin
            w = cw;
            h = (src_h_q * cw + src_w_q / 2) / src_w_q;
          end
        end
        x = place_axis(cx, cw, w, align_q[1:0]);
        y = place_axis(cy, ch, h, align_q[3:2]);
      end
    end
    r.x = saturate(x);
    r.y = saturate(y);
    r.w = saturate(w);
    r.h = saturate(h);
    return r;
  endfunction

  // Write one register at the next edge; the caller lowers the enable afterwards.
  task automatic write_reg(logic [2:0] idx, logic [CB-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_FIT_MODE:      mode_q = val[2:0];
      REG_ALIGNMENT:     align_q = val[3:0];
      REG_SOURCE_WIDTH:  src_w_q = longint'({1'b0, val[CB-2:0]});
      REG_SOURCE_HEIGHT: src_h_q = longint'({1'b0, val[CB-2:0]});
      REG_CUSTOM_X:      cust_x_q = longint'($signed(val));
      REG_CUSTOM_Y:      cust_y_q = longint'($signed(val));
      REG_CUSTOM_WIDTH:  cust_w_q = longint'($signed(val));
      default:           cust_h_q = longint'($signed(val));
    endcase
  endtask

  task automatic configure(logic [2:0] m, logic [3:0] a, logic [CB-2:0] sw, logic [CB-2:0] sh,
                           logic [CB-1:0] ux, logic [CB-1:0] uy, logic [CB-1:0] uw,
                           logic [CB-1:0] uh);
    write_reg(REG_FIT_MODE, CB'(m));
    write_reg(REG_ALIGNMENT, CB'(a));
    write_reg(REG_SOURCE_WIDTH, CB'(sw));
    write_reg(REG_SOURCE_HEIGHT, CB'(sh));
    write_reg(REG_CUSTOM_X, ux);
    write_reg(REG_CUSTOM_Y, uy);
    write_reg(REG_CUSTOM_WIDTH, uw);
    write_reg(REG_CUSTOM_HEIGHT, uh);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    config_phases++;
  endtask

  // Waits until every queued rectangle has been sent and answered, then lets
  // the pipeline drain before the registers may change again.
  task automatic wait_idle();
    while (pending_rects.size() != 0 || in_valid || expected_rects.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_rect(logic [CB-1:0] x, logic [CB-1:0] y, logic [CB-2:0] w,
                            logic [CB-2:0] h);
    content_rect_t c;
    c.cx = x; c.cy = y; c.cw = w; c.ch = h;
    pending_rects.push_back(c);
  endtask

  // Sizes: mostly moderate, some tiny, some at the extremes, some fully random.
  function automatic logic [CB-2:0] pick_size();
    case ($urandom_range(0, 5))
      0: return (CB - 1)'($urandom_range(0, 16));
      1: return $urandom_range(0, 1) ? '1 : '0;
      2: return (CB - 1)'($urandom);
      default: return (CB - 1)'($urandom_range(1, 20000));
    endcase
  endfunction

  function automatic logic [CB-1:0] pick_coord();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      1: return CB'($urandom);
      default: return CB'($signed($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  // Input driver: bursts of transactions separated by random gaps.
  always @(posedge clk_i) begin
    content_rect_t c;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        expected_rects.push_back(fit_rect('{content_x, content_y, content_w, content_h}));
        rects_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_rects.size() != 0) begin
          c = pending_rects.pop_front();
          content_x <= c.cx;
          content_y <= c.cy;
          content_w <= c.cw;
          content_h <= c.ch;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic signed [CB-1:0] exp_v,
                             logic signed [CB-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Output monitor: checks each accepted transaction and varies its stall style.
  always @(posedge clk_i) begin
    dest_rect_t e;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_rects.size() == 0) begin
          $error("unexpected output transaction");
          error_count++;
        end else begin
          e = expected_rects.pop_front();
          check_field("dest_x", e.x, dest_x);
          check_field("dest_y", e.y, dest_y);
          check_field("dest_w", e.w, dest_w);
          check_field("dest_h", e.h, dest_h);
          rects_checked++;
        end
      end
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left = $urandom_range(50, 300);
      end else begin
        style_left--;
      end
      if (stall_run > 0) begin
        stall_run--;
      end else begin
        case (stall_style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: begin
            out_stall <= $urandom_range(0, 1);
            stall_run = $urandom_range(0, 12);
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL image_fit_dest_rect");
      $finish;
    end
  end

  initial begin
    logic [CB-2:0] sw, sh;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    content_x = '0;
    content_y = '0;
    content_w = '0;
    content_h = '0;
    out_stall = 1'b0;
    // Shadow registers start at the reset values of the block.
    mode_q = MODE_NATURAL;
    align_q = 4'd5;
    src_w_q = 0; src_h_q = 0;
    cust_x_q = 0; cust_y_q = 0; cust_w_q = 0; cust_h_q = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: no image, so the content passes through.
    queue_rect(24'h012345, 24'hFEDCBA, 23'h000400, 23'h000300);
    wait_idle();

    // Directed: every mode, with extreme content and extreme custom values.
    for (int m = 0; m < 8; m++) begin
      configure(3'(m), 4'((m * 5) % 16), 23'h7FFFFF, 23'h000100,
                24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF);
      queue_rect(24'h7FFFFF, 24'h800000, 23'h7FFFFF, 23'h000000);
      queue_rect(24'h800000, 24'h7FFFFF, 23'h000000, 23'h7FFFFF);
      queue_rect(24'h001000, 24'hFFF000, 23'h004000, 23'h003000);
      wait_idle();
    end
    // Zero source height with a nonzero width is still no image.
    configure(MODE_CONTAIN, 4'hA, 23'h000200, 23'h000000, '0, '0, '0, '0);
    queue_rect(24'h000100, 24'h000100, 23'h001000, 23'h002000);
    wait_idle();

    // Random phases: random configuration, then a batch of rectangles.
    for (int p = 0; p < 25; p++) begin
      sw = pick_size();
      sh = pick_size();
      if ($urandom_range(0, 9) != 0 && sw == 0) sw = (CB - 1)'($urandom_range(1, 5000));
      if ($urandom_range(0, 9) != 0 && sh == 0) sh = (CB - 1)'($urandom_range(1, 5000));
      configure(($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4)),
                4'($urandom), sw, sh, pick_coord(), pick_coord(), pick_coord(),
                pick_coord());
      for (int i = 0; i < 70; i++)
        queue_rect(pick_coord(), pick_coord(), pick_size(), pick_size());
      wait_idle();
    end

    $display("%0d rectangles sent and %0d checked over %0d register settings",
             rects_sent, rects_checked, config_phases);
    if (error_count == 0) begin
      $display("PASS image_fit_dest_rect");
    end else begin
      $display("%0d mismatches", error_count);
      $display("FAIL image_fit_dest_rect");
    end
    $finish;
  end

endmodule
